### hw/rtl/rtse_pkg.sv
// Shared constants, codes and types of the record table sort engine.
// Depends on nothing; imported by every module of the block.
`default_nettype none
package rtse_pkg;
  localparam int SLOTS          = 32;
  localparam int NAME_WORDS     = 7;
  localparam int NAME_MAX_BYTES = 49;
  localparam int MAX_RESULTS    = 32;

  localparam int SLOT_W = $clog2(SLOTS);
  localparam int WORD_W = (NAME_WORDS > 1) ? $clog2(NAME_WORDS) : 1;
  localparam int ADDR_W = $clog2(SLOTS * NAME_WORDS);
  localparam int CNT_W  = $clog2(MAX_RESULTS);
  localparam int ID_W   = 27;
  localparam int AGE_W  = 8;

  localparam logic [2:0] OP_STAGE  = 3'd0;
  localparam logic [2:0] OP_INSERT = 3'd1;
  localparam logic [2:0] OP_DELETE = 3'd2;
  localparam logic [2:0] OP_SORT   = 3'd3;
  localparam logic [2:0] OP_READ   = 3'd4;

  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_FULL      = 3'd1;
  localparam logic [2:0] ST_DUP       = 3'd2;
  localparam logic [2:0] ST_BAD_AGE   = 3'd3;
  localparam logic [2:0] ST_NOT_FOUND = 3'd4;

  typedef struct packed {
    logic differ;
    logic a_gt;
  } cmp_t;

  typedef struct packed {
    logic [2:0]       status;
    logic [4:0]       slot;
    logic [ID_W-1:0]  id;
    logic [AGE_W-1:0] age;
    logic             active;
    logic [63:0]      word;
  } res_t;
endpackage
`default_nettype wire

### hw/rtl/rtse_cmp_unit.sv
// Shared compare unit of the sort: one name word pair or one id pair per use.
// Depends on rtse_pkg for the id width and the compare result type.
`default_nettype none
module rtse_cmp_unit (
  input  wire logic [63:0]            a_word,
  input  wire logic [63:0]            b_word,
  input  wire logic [rtse_pkg::ID_W-1:0] a_id,
  input  wire logic [rtse_pkg::ID_W-1:0] b_id,
  input  wire logic                   use_id,
  output rtse_pkg::cmp_t              result
);
  import rtse_pkg::*;

  // compare words as unsigned big-endian byte strings, ids as unsigned numbers
  always_comb begin
    if (use_id) begin
      result.differ = (a_id != b_id);
      result.a_gt   = (a_id > b_id);
    end else begin
      result.differ = (a_word != b_word);
      result.a_gt   = (a_word > b_word);
    end
  end
endmodule
`default_nettype wire

### hw/rtl/record_table_sort_engine_core.sv
// Top level of the record table sort engine: sequencer, record table, name memory.
// Depends on rtse_pkg and rtse_cmp_unit.
//
// Usage:
//   Requests enter on the in channel (in_valid/in_ready) with opcode, word_index,
//   name_word, person_id, person_age and slot_select. Results leave on the out
//   channel (out_valid/out_ready); last marks the final result of a request.
//   One request is worked at a time; in_ready is high only while the sequencer
//   is idle, but a finished result may still sit in the output register.
//   Work per request, from acceptance until the result is offered:
//     stage name word, unused opcode: the result only; read name word: one name read;
//     delete: one full walk of the table through one record port;
//     insert: the same walk, plus one name memory write per name word on success;
//     sort: about SLOTS*(SLOTS-1)/2 pair checks of active slots, comparing name
//       words in turn via the single-port name memory, a swap word by word,
//       then a listing walk of one slot a cycle while the output register is free.
//   Reset clears the table (no record active), the name staging and the
//   output register; the name memory is not cleared and needs no sweep.
//   A stalled receiver holds the output register; the sequencer waits before
//   each further result, so nothing is lost or repeated.
`default_nettype none
module record_table_sort_engine_core (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        in_valid,
  output logic                             in_ready,
  input  wire logic [2:0]                  opcode,
  input  wire logic [2:0]                  word_index,
  input  wire logic [63:0]                 name_word,
  input  wire logic [rtse_pkg::ID_W-1:0]   person_id,
  input  wire logic [rtse_pkg::AGE_W-1:0]  person_age,
  input  wire logic [4:0]                  slot_select,
  output logic                             out_valid,
  input  wire logic                        out_ready,
  output logic [2:0]                       status,
  output logic [4:0]                       slot,
  output logic [rtse_pkg::ID_W-1:0]        out_id,
  output logic [rtse_pkg::AGE_W-1:0]       out_age,
  output logic                             out_active,
  output logic [63:0]                      out_name_word,
  output logic                             last
);
  import rtse_pkg::*;

  // sequencer states
  localparam logic [4:0] S_IDLE     = 5'd0;
  localparam logic [4:0] S_EMIT     = 5'd1;
  localparam logic [4:0] S_INS_SCAN = 5'd2;
  localparam logic [4:0] S_INS_DEC  = 5'd3;
  localparam logic [4:0] S_INS_WR   = 5'd4;
  localparam logic [4:0] S_DEL_SCAN = 5'd5;
  localparam logic [4:0] S_DEL_DEC  = 5'd6;
  localparam logic [4:0] S_SORT_I   = 5'd7;
  localparam logic [4:0] S_SORT_J   = 5'd8;
  localparam logic [4:0] S_CMP_A    = 5'd9;
  localparam logic [4:0] S_CMP_B    = 5'd10;
  localparam logic [4:0] S_CMP_C    = 5'd11;
  localparam logic [4:0] S_CMP_ID   = 5'd12;
  localparam logic [4:0] S_SW_A     = 5'd13;
  localparam logic [4:0] S_SW_B     = 5'd14;
  localparam logic [4:0] S_SW_C     = 5'd15;
  localparam logic [4:0] S_SW_D     = 5'd16;
  localparam logic [4:0] S_SW_REC   = 5'd17;
  localparam logic [4:0] S_LIST     = 5'd18;
  localparam logic [4:0] S_RD_A     = 5'd19;
  localparam logic [4:0] S_RD_B     = 5'd20;

  localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(SLOTS - 1);
  localparam logic [WORD_W-1:0] WORD_LAST = WORD_W'(NAME_WORDS - 1);
  localparam logic [CNT_W-1:0]  CNT_LAST  = CNT_W'(MAX_RESULTS - 1);

  logic [4:0] state;

  // record table
  logic [ID_W-1:0]  rec_id    [SLOTS];
  logic [AGE_W-1:0] rec_age   [SLOTS];
  logic [SLOTS-1:0] rec_valid;
  logic [63:0]      name_staging [NAME_WORDS];

  // name memory, one port: one write or one registered read a cycle
  logic [63:0]       name_mem [SLOTS * NAME_WORDS];
  logic [63:0]       rd_data;
  logic [ADDR_W-1:0] mem_addr;
  logic              mem_we;
  logic [63:0]       mem_wdata;

  // latched request
  logic [2:0]        wi_q;
  logic              wi_ok;
  logic [ID_W-1:0]   id_q;
  logic [AGE_W-1:0]  age_q;
  logic [SLOT_W-1:0] sel_q;

  // walk and sort indexes
  logic [SLOT_W-1:0] idx;
  logic [SLOT_W-1:0] i_idx;
  logic [SLOT_W-1:0] j_idx;
  logic [WORD_W-1:0] w_cnt;
  logic [CNT_W-1:0]  list_cnt;
  logic              ended;

  logic              free_found;
  logic [SLOT_W-1:0] free_slot;
  logic              hit_found;
  logic [SLOT_W-1:0] hit_slot;
  logic [AGE_W-1:0]  hit_age;

  logic [ID_W-1:0]   cur_id;
  logic [AGE_W-1:0]  cur_age;
  logic [63:0]       word_a;
  res_t              res;

  // shared record read port
  logic [SLOT_W-1:0] rec_idx;
  logic [ID_W-1:0]   mux_id;
  logic [AGE_W-1:0]  mux_age;
  logic              mux_valid;

  cmp_t              cmp;
  logic              cmp_use_id;
  logic [64:0]       norm;
  logic [SLOTS-1:0]  upper_valid;
  logic              list_last;
  logic              out_free;
  logic              accept;
  logic              load_out;

  function automatic logic [ADDR_W-1:0] name_addr(input logic [SLOT_W-1:0] s,
                                                  input logic [WORD_W-1:0] w);
    return ADDR_W'(s) * ADDR_W'(NAME_WORDS) + ADDR_W'(w);
  endfunction

  // cut the staged name at its first zero byte and at the byte limit
  function automatic logic [64:0] norm_word(input logic [63:0] src,
                                            input logic [WORD_W-1:0] w,
                                            input logic ended_in);
    logic        end_f;
    logic [63:0] dst;
    logic [7:0]  b8;
    int          pos;
    end_f = ended_in;
    dst   = '0;
    for (int b = 0; b < 8; b++) begin
      b8  = src[63-8*b -: 8];
      pos = int'(w) * 8 + b;
      if (pos >= NAME_MAX_BYTES || b8 == 8'd0) end_f = 1'b1;
      if (!end_f) dst[63-8*b -: 8] = b8;
    end
    return {end_f, dst};
  endfunction

  assign in_ready = (state == S_IDLE);
  assign accept   = in_valid && in_ready;
  assign out_free = !out_valid || out_ready;
  // a new result enters the output register this cycle
  assign load_out = out_free && ((state == S_EMIT) || (state == S_LIST && mux_valid));

  always_comb begin
    case (state)
      S_SORT_I:                         rec_idx = i_idx;
      S_SORT_J, S_CMP_ID, S_SW_REC:     rec_idx = j_idx;
      S_RD_B:                           rec_idx = sel_q;
      default:                          rec_idx = idx;
    endcase
  end

  assign mux_id    = rec_id[rec_idx];
  assign mux_age   = rec_age[rec_idx];
  assign mux_valid = rec_valid[rec_idx];

  assign norm        = norm_word(name_staging[w_cnt], w_cnt, ended);
  assign upper_valid = rec_valid & ~((SLOTS'(2) << idx) - SLOTS'(1));
  assign list_last   = (upper_valid == '0) || (list_cnt == CNT_LAST);
  assign cmp_use_id  = (state == S_CMP_ID);

  always_comb begin
    mem_we    = 1'b0;
    mem_wdata = rd_data;
    case (state)
      S_INS_WR: begin
        mem_addr  = name_addr(free_slot, w_cnt);
        mem_we    = 1'b1;
        mem_wdata = norm[63:0];
      end
      S_CMP_A, S_SW_A: mem_addr = name_addr(i_idx, w_cnt);
      S_SW_C: begin
        mem_addr = name_addr(i_idx, w_cnt);
        mem_we   = 1'b1;
      end
      S_CMP_B, S_SW_B: mem_addr = name_addr(j_idx, w_cnt);
      S_SW_D: begin
        mem_addr  = name_addr(j_idx, w_cnt);
        mem_we    = 1'b1;
        mem_wdata = word_a;
      end
      S_RD_A:  mem_addr = name_addr(sel_q, WORD_W'(wi_q));
      default: mem_addr = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) name_mem[mem_addr] <= mem_wdata;
    rd_data <= name_mem[mem_addr];
  end

  rtse_cmp_unit u_cmp (
    .a_word (word_a),
    .b_word (rd_data),
    .a_id   (cur_id),
    .b_id   (mux_id),
    .use_id (cmp_use_id),
    .result (cmp)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
      rec_valid <= '0;
      for (int k = 0; k < SLOTS; k++) begin
        rec_id[k]  <= '0;
        rec_age[k] <= '0;
      end
      for (int k = 0; k < NAME_WORDS; k++) name_staging[k] <= '0;
    end else begin
      if (out_valid && out_ready && !load_out) out_valid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (accept) begin
            wi_q  <= word_index;
            wi_ok <= (32'(word_index) < NAME_WORDS);
            id_q  <= person_id;
            age_q <= person_age;
            sel_q <= SLOT_W'(slot_select);
            idx   <= '0;
            res   <= '0;
            free_found <= 1'b0;
            hit_found  <= 1'b0;
            case (opcode)
              OP_STAGE: begin
                if (32'(word_index) < NAME_WORDS)
                  name_staging[WORD_W'(word_index)] <= name_word;
                state <= S_EMIT;
              end
              OP_INSERT: state <= S_INS_SCAN;
              OP_DELETE: state <= S_DEL_SCAN;
              OP_SORT: begin
                i_idx <= '0;
                state <= S_SORT_I;
              end
              OP_READ: begin
                if (32'(slot_select) >= SLOTS) begin
                  res.status <= ST_NOT_FOUND;
                  state      <= S_EMIT;
                end else begin
                  state <= S_RD_A;
                end
              end
              default: state <= S_EMIT;
            endcase
          end
        end

        S_EMIT: begin
          if (out_free) begin
            out_valid     <= 1'b1;
            status        <= res.status;
            slot          <= res.slot;
            out_id        <= res.id;
            out_age       <= res.age;
            out_active    <= res.active;
            out_name_word <= res.word;
            last          <= 1'b1;
            state         <= S_IDLE;
          end
        end

        // one walk finds the lowest free slot and the lowest active duplicate
        S_INS_SCAN: begin
          if (!mux_valid && !free_found) begin
            free_found <= 1'b1;
            free_slot  <= idx;
          end
          if (mux_valid && mux_id == id_q && !hit_found) begin
            hit_found <= 1'b1;
            hit_slot  <= idx;
            hit_age   <= mux_age;
          end
          if (idx == SLOT_LAST) state <= S_INS_DEC;
          else idx <= idx + SLOT_W'(1);
        end

        S_INS_DEC: begin
          if (!free_found) begin
            res.status <= ST_FULL;
            state      <= S_EMIT;
          end else if (hit_found) begin
            res.status <= ST_DUP;
            res.slot   <= 5'(hit_slot);
            res.id     <= id_q;
            res.age    <= hit_age;
            res.active <= 1'b1;
            state      <= S_EMIT;
          end else if (age_q == '0) begin
            res.status <= ST_BAD_AGE;
            res.slot   <= 5'(free_slot);
            state      <= S_EMIT;
          end else begin
            w_cnt <= '0;
            ended <= 1'b0;
            state <= S_INS_WR;
          end
        end

        S_INS_WR: begin
          ended <= norm[64];
          if (w_cnt == WORD_LAST) begin
            rec_id[free_slot]    <= id_q;
            rec_age[free_slot]   <= age_q;
            rec_valid[free_slot] <= 1'b1;
            res.slot   <= 5'(free_slot);
            res.id     <= id_q;
            res.age    <= age_q;
            res.active <= 1'b1;
            state      <= S_EMIT;
          end else begin
            w_cnt <= w_cnt + WORD_W'(1);
          end
        end

        S_DEL_SCAN: begin
          if (mux_valid && mux_id == id_q && !hit_found) begin
            hit_found <= 1'b1;
            hit_slot  <= idx;
            hit_age   <= mux_age;
          end
          if (idx == SLOT_LAST) state <= S_DEL_DEC;
          else idx <= idx + SLOT_W'(1);
        end

        S_DEL_DEC: begin
          if (hit_found) begin
            rec_valid[hit_slot] <= 1'b0;
            res.slot <= 5'(hit_slot);
            res.id   <= id_q;
            res.age  <= hit_age;
          end else begin
            res.status <= ST_NOT_FOUND;
          end
          state <= S_EMIT;
        end

        // exchange sort over active pairs (i, j), j above i
        S_SORT_I: begin
          if (i_idx == SLOT_LAST) begin
            idx      <= '0;
            list_cnt <= '0;
            state    <= S_LIST;
          end else if (!mux_valid) begin
            i_idx <= i_idx + SLOT_W'(1);
          end else begin
            cur_id  <= mux_id;
            cur_age <= mux_age;
            j_idx   <= i_idx + SLOT_W'(1);
            state   <= S_SORT_J;
          end
        end

        S_SORT_J: begin
          if (mux_valid) begin
            w_cnt <= '0;
            state <= S_CMP_A;
          end else if (j_idx == SLOT_LAST) begin
            i_idx <= i_idx + SLOT_W'(1);
            state <= S_SORT_I;
          end else begin
            j_idx <= j_idx + SLOT_W'(1);
          end
        end

        S_CMP_A: state <= S_CMP_B;

        S_CMP_B: begin
          word_a <= rd_data;
          state  <= S_CMP_C;
        end

        S_CMP_C: begin
          if (cmp.differ || w_cnt == WORD_LAST) begin
            if (cmp.differ && cmp.a_gt) begin
              w_cnt <= '0;
              state <= S_SW_A;
            end else if (cmp.differ) begin
              if (j_idx == SLOT_LAST) begin
                i_idx <= i_idx + SLOT_W'(1);
                state <= S_SORT_I;
              end else begin
                j_idx <= j_idx + SLOT_W'(1);
                state <= S_SORT_J;
              end
            end else begin
              state <= S_CMP_ID;
            end
          end else begin
            w_cnt <= w_cnt + WORD_W'(1);
            state <= S_CMP_A;
          end
        end

        S_CMP_ID: begin
          if (cmp.a_gt) begin
            w_cnt <= '0;
            state <= S_SW_A;
          end else if (j_idx == SLOT_LAST) begin
            i_idx <= i_idx + SLOT_W'(1);
            state <= S_SORT_I;
          end else begin
            j_idx <= j_idx + SLOT_W'(1);
            state <= S_SORT_J;
          end
        end

        // swap names word by word through the single memory port
        S_SW_A: state <= S_SW_B;

        S_SW_B: begin
          word_a <= rd_data;
          state  <= S_SW_C;
        end

        S_SW_C: state <= S_SW_D;

        S_SW_D: begin
          if (w_cnt == WORD_LAST) state <= S_SW_REC;
          else begin
            w_cnt <= w_cnt + WORD_W'(1);
            state <= S_SW_A;
          end
        end

        S_SW_REC: begin
          rec_id[i_idx]  <= mux_id;
          rec_age[i_idx] <= mux_age;
          rec_id[j_idx]  <= cur_id;
          rec_age[j_idx] <= cur_age;
          cur_id  <= mux_id;
          cur_age <= mux_age;
          if (j_idx == SLOT_LAST) begin
            i_idx <= i_idx + SLOT_W'(1);
            state <= S_SORT_I;
          end else begin
            j_idx <= j_idx + SLOT_W'(1);
            state <= S_SORT_J;
          end
        end

        // list active slots; hold while the output register is full
        S_LIST: begin
          if (mux_valid) begin
            if (out_free) begin
              out_valid     <= 1'b1;
              status        <= ST_OK;
              slot          <= 5'(idx);
              out_id        <= mux_id;
              out_age       <= mux_age;
              out_active    <= 1'b1;
              out_name_word <= '0;
              last          <= list_last;
              list_cnt      <= list_cnt + CNT_W'(1);
              if (list_last) state <= S_IDLE;
              else idx <= idx + SLOT_W'(1);
            end
          end else if (idx == SLOT_LAST) begin
            state <= S_EMIT;
          end else begin
            idx <= idx + SLOT_W'(1);
          end
        end

        S_RD_A: state <= S_RD_B;

        S_RD_B: begin
          res.slot   <= 5'(sel_q);
          res.id     <= mux_id;
          res.age    <= mux_age;
          res.active <= mux_valid;
          res.word   <= wi_ok ? rd_data : 64'd0;
          state      <= S_EMIT;
        end

        default: state <= S_IDLE;
      endcase
    end
  end

  // at most one slot changes its valid mark per cycle
  a_valid_step: assert property (@(posedge clk) disable iff (rst)
    $countones(rec_valid ^ $past(rec_valid)) <= 1)
    else $error("more than one valid mark changed in a cycle");

  // sorting never changes which slots are active
  a_sort_keeps_valid: assert property (@(posedge clk) disable iff (rst)
    (state == S_SORT_J || state == S_CMP_C || state == S_SW_D || state == S_SW_REC)
    |=> $stable(rec_valid))
    else $error("valid marks changed during sort");

  // the name memory is written only while a request is being worked
  a_no_idle_write: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE || state == S_EMIT || state == S_LIST) |-> !mem_we)
    else $error("name memory written outside insert or swap");

  // a completed insert leaves its slot active
  a_insert_sets: assert property (@(posedge clk) disable iff (rst)
    (state == S_INS_WR && w_cnt == WORD_LAST) |=> rec_valid[free_slot])
    else $error("insert did not mark its slot active");
endmodule
`default_nettype wire
